FILE: src/power_window_controller_assert.svh
// Assertion macros for the port-level checker.
`ifndef POWER_WINDOW_CONTROLLER_ASSERT_SVH
`define POWER_WINDOW_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("power window controller check failed");

// Next-cycle implication, disabled while reset is held.
`define PWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("power window controller check failed");

`endif

FILE: src/pwc_pkg.sv
// Shared types and codes for the power window controller.
`timescale 1ns / 1ps

package pwc_pkg;

    localparam int unsigned OtWidth    = 10;
    localparam int unsigned RtWidth    = 12;
    localparam int unsigned TimerWidth = 12;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ONE_TOUCH = 2'd0;
    localparam logic [1:0] REG_REVERSE   = 2'd1;

    localparam logic [OtWidth-1:0] ONE_TOUCH_RESET = 10'd100;
    localparam logic [RtWidth-1:0] REVERSE_RESET   = 12'd500;

    // Phase codes
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_JUDGE_UP   = 3'd1;
    localparam logic [2:0] PH_JUDGE_DOWN = 3'd2;
    localparam logic [2:0] PH_HELD_UP    = 3'd3;
    localparam logic [2:0] PH_HELD_DOWN  = 3'd4;
    localparam logic [2:0] PH_REVERSE    = 3'd5;

    // Position codes
    localparam logic [2:0] POS_FULL_UP   = 3'd0;
    localparam logic [2:0] POS_FULL_DOWN = 3'd1;
    localparam logic [2:0] POS_BETWEEN   = 3'd2;
    localparam logic [2:0] POS_MAN_UP    = 3'd3;
    localparam logic [2:0] POS_MAN_DOWN  = 3'd4;
    localparam logic [2:0] POS_AUTO_UP   = 3'd5;
    localparam logic [2:0] POS_AUTO_DOWN = 3'd6;

    // Motor codes
    localparam logic [1:0] MOT_OFF  = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_DOWN = 2'd2;

    typedef struct packed {
        logic up_button;
        logic down_button;
        logic limit_hit;
        logic jam_seen;
    } lane_in_t;

    typedef struct packed {
        logic [1:0] motor;
        logic [2:0] position;
    } lane_out_t;

    typedef struct packed {
        lane_out_t w1;
        lane_out_t w2;
    } result_t;

endpackage

FILE: src/pwc_lane.sv
// One window lane: per-tick state update for a single window.
`timescale 1ns / 1ps

module pwc_lane (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  pwc_pkg::lane_in_t                lane_in,
    input  logic [pwc_pkg::OtWidth-1:0]      one_touch_ticks,
    input  logic [pwc_pkg::RtWidth-1:0]      reverse_ticks,
    output pwc_pkg::lane_out_t               lane_out
);

    logic [2:0]                         pos_reg, pos_next;
    logic [2:0]                         phase_reg, phase_next;
    logic [pwc_pkg::TimerWidth-1:0]     timer_reg, timer_next;
    logic [1:0]                         motor_reg, motor_next;
    logic                               last_up_reg, last_up_next;
    logic                               last_down_reg, last_down_next;

    logic [pwc_pkg::TimerWidth-1:0]     ot_load;
    logic [pwc_pkg::TimerWidth-1:0]     rt_load;
    logic [pwc_pkg::TimerWidth-1:0]     timer_dec;
    logic [2:0]                         pos_lim;
    logic                               jam_take;
    logic                               up_edge;
    logic                               down_edge;
    logic                               level;

    // A zero register value acts as one
    assign ot_load = (one_touch_ticks == '0) ? pwc_pkg::TimerWidth'(1)
                                              : pwc_pkg::TimerWidth'(one_touch_ticks);
    assign rt_load = (reverse_ticks == '0) ? pwc_pkg::TimerWidth'(1) : reverse_ticks;
    assign timer_dec = timer_reg - pwc_pkg::TimerWidth'(1);

    assign up_edge   = lane_in.up_button & ~last_up_reg;
    assign down_edge = lane_in.down_button & ~last_down_reg;
    assign jam_take  = ~lane_in.limit_hit & lane_in.jam_seen &
                       (pos_reg == pwc_pkg::POS_AUTO_UP) & (phase_reg != pwc_pkg::PH_REVERSE);

    always_comb begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        motor_next     = motor_reg;
        last_up_next   = lane_in.up_button;
        last_down_next = lane_in.down_button;
        level          = 1'b0;
        pos_lim        = pos_reg;

        // Limit first: it wins over a jam in the same tick
        if (lane_in.limit_hit) begin
            if (pos_reg inside {pwc_pkg::POS_MAN_UP, pwc_pkg::POS_AUTO_UP}) begin
                motor_next = pwc_pkg::MOT_OFF;
                pos_lim    = pwc_pkg::POS_FULL_UP;
            end else if (pos_reg inside {pwc_pkg::POS_MAN_DOWN, pwc_pkg::POS_AUTO_DOWN}) begin
                motor_next = pwc_pkg::MOT_OFF;
                pos_lim    = pwc_pkg::POS_FULL_DOWN;
            end
        end
        pos_next = pos_lim;

        if (jam_take) begin
            pos_next   = pwc_pkg::POS_AUTO_DOWN;
            motor_next = pwc_pkg::MOT_DOWN;
            phase_next = pwc_pkg::PH_REVERSE;
            timer_next = rt_load;
        end else begin
            case (phase_reg)
                pwc_pkg::PH_IDLE: begin
                    if (up_edge && (pos_lim inside {pwc_pkg::POS_BETWEEN, pwc_pkg::POS_FULL_DOWN,
                                    pwc_pkg::POS_MAN_DOWN, pwc_pkg::POS_AUTO_DOWN})) begin
                        phase_next = pwc_pkg::PH_JUDGE_UP;
                        timer_next = ot_load;
                    end else if (down_edge && (pos_lim inside {pwc_pkg::POS_BETWEEN,
                                 pwc_pkg::POS_FULL_UP, pwc_pkg::POS_MAN_UP,
                                 pwc_pkg::POS_AUTO_UP})) begin
                        phase_next = pwc_pkg::PH_JUDGE_DOWN;
                        timer_next = ot_load;
                    end
                end
                pwc_pkg::PH_JUDGE_UP, pwc_pkg::PH_JUDGE_DOWN: begin
                    timer_next = timer_dec;
                    if (timer_dec == '0) begin
                        if (phase_reg == pwc_pkg::PH_JUDGE_UP) begin
                            motor_next = pwc_pkg::MOT_UP;
                            if (!lane_in.up_button) begin
                                pos_next   = pwc_pkg::POS_AUTO_UP;
                                phase_next = pwc_pkg::PH_IDLE;
                            end else begin
                                pos_next   = pwc_pkg::POS_MAN_UP;
                                phase_next = pwc_pkg::PH_HELD_UP;
                            end
                        end else begin
                            motor_next = pwc_pkg::MOT_DOWN;
                            if (!lane_in.down_button) begin
                                pos_next   = pwc_pkg::POS_AUTO_DOWN;
                                phase_next = pwc_pkg::PH_IDLE;
                            end else begin
                                pos_next   = pwc_pkg::POS_MAN_DOWN;
                                phase_next = pwc_pkg::PH_HELD_DOWN;
                            end
                        end
                    end
                end
                pwc_pkg::PH_HELD_UP, pwc_pkg::PH_HELD_DOWN: begin
                    level = (phase_reg == pwc_pkg::PH_HELD_UP) ? lane_in.up_button
                                                               : lane_in.down_button;
                    if (!level) begin
                        // Stop in between only if still moving manually that way
                        if ((phase_reg == pwc_pkg::PH_HELD_UP && pos_lim == pwc_pkg::POS_MAN_UP) ||
                            (phase_reg == pwc_pkg::PH_HELD_DOWN &&
                             pos_lim == pwc_pkg::POS_MAN_DOWN)) begin
                            motor_next = pwc_pkg::MOT_OFF;
                            pos_next   = pwc_pkg::POS_BETWEEN;
                        end
                        phase_next = pwc_pkg::PH_IDLE;
                    end
                end
                pwc_pkg::PH_REVERSE: begin
                    timer_next = timer_dec;
                    if (timer_dec == '0) begin
                        motor_next = pwc_pkg::MOT_OFF;
                        if (pos_lim == pwc_pkg::POS_AUTO_DOWN) begin
                            pos_next = pwc_pkg::POS_BETWEEN;
                        end
                        phase_next = pwc_pkg::PH_IDLE;
                    end
                end
                default: begin
                    phase_next = pwc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= pwc_pkg::POS_FULL_UP;
            phase_reg     <= pwc_pkg::PH_IDLE;
            timer_reg     <= '0;
            motor_reg     <= pwc_pkg::MOT_OFF;
            last_up_reg   <= 1'b0;
            last_down_reg <= 1'b0;
        end else if (advance) begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            motor_reg     <= motor_next;
            last_up_reg   <= last_up_next;
            last_down_reg <= last_down_next;
        end
    end

    // The result of a tick is the state after it
    assign lane_out.motor    = motor_next;
    assign lane_out.position = pos_next;

endmodule

FILE: src/pwc_merge.sv
// Merge stage: joins both lane results into one output register with a skid slot.
`timescale 1ns / 1ps

module pwc_merge (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_xfer,
    input  pwc_pkg::lane_out_t w1_in,
    input  pwc_pkg::lane_out_t w2_in,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output pwc_pkg::result_t   out_data
);

    pwc_pkg::result_t merged;
    pwc_pkg::result_t out_data_reg, out_data_next;
    pwc_pkg::result_t skid_data_reg, skid_data_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    assign merged.w1 = w1_in;
    assign merged.w2 = w2_in;

    always_comb begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !out_ready) begin
            // Output stalled: park a new result in the skid slot
            if (in_xfer) begin
                skid_data_next  = merged;
                skid_valid_next = 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_data_next   = skid_data_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end else begin
            out_data_next  = merged;
            out_valid_next = in_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/power_window_controller.sv
// A tick's result is registered in the merge output register, or in its skid slot while the output stalls.
// Throughput: one tick per cycle while the skid slot is empty; both window lanes update in the same cycle.
// An output register plus a skid slot keep input open while one result waits.
// Reset (aresetn low, synchronous): both windows fully up, idle, motors off,
// registers back to 100 and 500 ticks, no result pending.
`timescale 1ns / 1ps

module power_window_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_w1_up_button,
    input  logic        s_w1_down_button,
    input  logic        s_w1_limit_hit,
    input  logic        s_w1_jam_seen,
    input  logic        s_w2_up_button,
    input  logic        s_w2_down_button,
    input  logic        s_w2_limit_hit,
    input  logic        s_w2_jam_seen,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_w1_motor,
    output logic [2:0]  m_w1_position,
    output logic [1:0]  m_w2_motor,
    output logic [2:0]  m_w2_position
);

    logic [pwc_pkg::OtWidth-1:0] one_touch_reg;
    logic [pwc_pkg::RtWidth-1:0] reverse_reg;
    logic                        in_xfer;
    pwc_pkg::lane_in_t           w1_in;
    pwc_pkg::lane_in_t           w2_in;
    pwc_pkg::lane_out_t          w1_out;
    pwc_pkg::lane_out_t          w2_out;
    pwc_pkg::result_t            result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_touch_reg <= pwc_pkg::ONE_TOUCH_RESET;
            reverse_reg   <= pwc_pkg::REVERSE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                pwc_pkg::REG_ONE_TOUCH: one_touch_reg <= cfg_data[pwc_pkg::OtWidth-1:0];
                pwc_pkg::REG_REVERSE:   reverse_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_xfer = s_valid & s_ready;

    assign w1_in = '{up_button: s_w1_up_button, down_button: s_w1_down_button,
                     limit_hit: s_w1_limit_hit, jam_seen: s_w1_jam_seen};
    assign w2_in = '{up_button: s_w2_up_button, down_button: s_w2_down_button,
                     limit_hit: s_w2_limit_hit, jam_seen: s_w2_jam_seen};

    pwc_lane u_lane_w1 (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (in_xfer),
        .lane_in         (w1_in),
        .one_touch_ticks (one_touch_reg),
        .reverse_ticks   (reverse_reg),
        .lane_out        (w1_out)
    );

    pwc_lane u_lane_w2 (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (in_xfer),
        .lane_in         (w2_in),
        .one_touch_ticks (one_touch_reg),
        .reverse_ticks   (reverse_reg),
        .lane_out        (w2_out)
    );

    pwc_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_xfer   (in_xfer),
        .w1_in     (w1_out),
        .w2_in     (w2_out),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result)
    );

    assign m_w1_motor    = result.w1.motor;
    assign m_w1_position = result.w1.position;
    assign m_w2_motor    = result.w2.motor;
    assign m_w2_position = result.w2.position;

endmodule

FILE: src/pwc_checker.sv
// Port-level checker for the power window controller, bound to the top level.
`timescale 1ns / 1ps
`include "power_window_controller_assert.svh"

module pwc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_w1_motor,
    input logic [2:0] m_w1_position,
    input logic [1:0] m_w2_motor,
    input logic [2:0] m_w2_position
);

    // Motor direction always agrees with the recorded position
    `PWC_ASSERT_NOW(a_w1_motor_matches_pos, aclk, aresetn, m_valid, ((m_w1_motor == pwc_pkg::MOT_UP) == (m_w1_position == pwc_pkg::POS_MAN_UP || m_w1_position == pwc_pkg::POS_AUTO_UP)) && ((m_w1_motor == pwc_pkg::MOT_DOWN) == (m_w1_position == pwc_pkg::POS_MAN_DOWN || m_w1_position == pwc_pkg::POS_AUTO_DOWN)))
    `PWC_ASSERT_NOW(a_w2_motor_matches_pos, aclk, aresetn, m_valid, ((m_w2_motor == pwc_pkg::MOT_UP) == (m_w2_position == pwc_pkg::POS_MAN_UP || m_w2_position == pwc_pkg::POS_AUTO_UP)) && ((m_w2_motor == pwc_pkg::MOT_DOWN) == (m_w2_position == pwc_pkg::POS_MAN_DOWN || m_w2_position == pwc_pkg::POS_AUTO_DOWN)))
    `PWC_ASSERT_NOW(a_codes_in_range, aclk, aresetn, m_valid, m_w1_motor != 2'd3 && m_w2_motor != 2'd3 && m_w1_position != 3'd7 && m_w2_position != 3'd7)
    // Input only closes when a result is already waiting
    `PWC_ASSERT_NOW(a_stall_needs_result, aclk, aresetn, !s_ready, m_valid)
    `PWC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid)

endmodule

bind power_window_controller pwc_checker u_pwc_checker (.*);
